// ===== sv/cdw_pkg.sv =====
// ----------------------------------------------------------------------------
// cdw_pkg
// Shared types, constants and calendar helpers for the calendar date counter.
// ----------------------------------------------------------------------------
package cdw_pkg;

  localparam int YEAR_W       = 14;
  localparam int DAY_W        = 5;
  localparam int MONTH_W      = 4;
  localparam int WD_W         = 3;
  localparam int YEAR_MAX_DEF = 9999;

  localparam logic [YEAR_W-1:0]  CUTOVER_YEAR = 14'd1916;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR    = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_APR    = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_SKIP_TO  = 5'd14;
  localparam logic [DAY_W-1:0]   DAY_LAST_MAR = 5'd31;
  localparam logic [WD_W-1:0]    WD_SAT       = 3'd6;
  localparam logic [WD_W-1:0]    WD_SUN       = 3'd7;
  localparam logic [6:0]         C100_LAST    = 7'd99;
  localparam logic [8:0]         C400_LAST    = 9'd399;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_t;

  typedef enum logic {
    CMD_SET  = 1'b0,
    CMD_NEXT = 1'b1
  } cmd_t;

  typedef struct packed {
    logic       done;
    logic       leap;
    logic [2:0] acc;
    logic [1:0] c4;
    logic [6:0] c100;
    logic [8:0] c400;
  } walk_res_t;

  function automatic logic leap_f(input logic [YEAR_W-1:0] yr, input logic [1:0] c4,
                                  input logic [6:0] c100, input logic [8:0] c400);
    logic l;
    if (yr <= CUTOVER_YEAR) begin
      l = (c4 == 2'd0);
    end else begin
      l = ((c4 == 2'd0) && (c100 != 7'd0)) || (c400 == 9'd0);
    end
    return l;
  endfunction

  function automatic logic [DAY_W-1:0] month_len_f(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] days_before_mod7_f(input logic [MONTH_W-1:0] m);
    logic [2:0] r;
    unique case (m)
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd3;
      4'd4:    r = 3'd6;
      4'd5:    r = 3'd1;
      4'd6:    r = 3'd4;
      4'd7:    r = 3'd6;
      4'd8:    r = 3'd2;
      4'd9:    r = 3'd5;
      4'd10:   r = 3'd0;
      4'd11:   r = 3'd3;
      4'd12:   r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] mod7_f(input logic [5:0] v);
    logic [5:0] t;
    t = v;
    for (int i = 0; i < 7; i++) begin
      if (t >= 6'd7) begin
        t = t - 6'd7;
      end
    end
    return t[2:0];
  endfunction

endpackage

// ===== sv/cdw_walk.sv =====
// ----------------------------------------------------------------------------
// cdw_walk
// Year walker: steps one year per cycle from year 1 to the target year,
// tracking year mod 4/100/400 and the weekday offset mod 7.
// ----------------------------------------------------------------------------
module cdw_walk
  import cdw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [YEAR_W-1:0] target_year,
  output walk_res_t         res
);

  logic              busy_r, busy_nxt;
  logic [YEAR_W-1:0] tgt_r, tgt_nxt;
  logic [YEAR_W-1:0] yr_r, yr_nxt;
  logic [1:0]        c4_r, c4_nxt;
  logic [6:0]        c100_r, c100_nxt;
  logic [8:0]        c400_r, c400_nxt;
  logic [2:0]        acc_r, acc_nxt;
  logic              leap_cur;
  logic              at_tgt;
  logic [3:0]        acc_sum;

  assign leap_cur = leap_f(yr_r, c4_r, c100_r, c400_r);
  assign at_tgt   = (yr_r == tgt_r);
  assign acc_sum  = {1'b0, acc_r} + (leap_cur ? 4'd2 : 4'd1);

  always_comb begin
    busy_nxt = busy_r;
    tgt_nxt  = tgt_r;
    yr_nxt   = yr_r;
    c4_nxt   = c4_r;
    c100_nxt = c100_r;
    c400_nxt = c400_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      tgt_nxt  = target_year;
      yr_nxt   = 14'd1;
      c4_nxt   = 2'd1;
      c100_nxt = 7'd1;
      c400_nxt = 9'd1;
      acc_nxt  = 3'd0;
    end else if (busy_r) begin
      if (at_tgt) begin
        busy_nxt = 1'b0;
      end else begin
        yr_nxt   = yr_r + 14'd1;
        c4_nxt   = c4_r + 2'd1;
        c100_nxt = (c100_r == C100_LAST) ? 7'd0 : c100_r + 7'd1;
        c400_nxt = (c400_r == C400_LAST) ? 9'd0 : c400_r + 9'd1;
        acc_nxt  = (acc_sum >= 4'd7) ? 3'(acc_sum - 4'd7) : acc_sum[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    tgt_r  <= tgt_nxt;
    yr_r   <= yr_nxt;
    c4_r   <= c4_nxt;
    c100_r <= c100_nxt;
    c400_r <= c400_nxt;
    acc_r  <= acc_nxt;
  end

  assign res.done = busy_r && at_tgt;
  assign res.leap = leap_cur;
  assign res.acc  = acc_r;
  assign res.c4   = c4_r;
  assign res.c100 = c100_r;
  assign res.c400 = c400_r;

endmodule

// ===== sv/calendar_date_counter_weekday.sv =====
// ----------------------------------------------------------------------------
// calendar_date_counter_weekday
// Calendar date and weekday counter with Julian/Gregorian cutover in 1916.
//
//   channel | ports              | tdata / tuser
//   input   | in_tvalid/tready   | tdata: set_day, set_month, set_year; tuser: cmd
//   result  | out_tvalid/tready  | tdata: cur_day, cur_month, cur_year, weekday
//
// A next-day result is registered as the transaction is accepted. In a set transaction
// the year walker steps one year per cycle from year 1 to the sanitized set_year.
// One transaction at a time; a result waiting on the output holds off the next
// input transaction unless it is taken in the same cycle.
// Reset gives 1.1.1, Saturday.
// ----------------------------------------------------------------------------
module calendar_date_counter_weekday
  import cdw_pkg::*;
#(
  parameter int YEAR_MAX = YEAR_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // set_day[4:0], set_month[8:5], set_year[22:9]
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // cur_day[4:0], cur_month[8:5], cur_year[22:9],
                                  // weekday[25:23]
);

  localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(YEAR_MAX);

  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [WD_W-1:0]    wd_r, wd_nxt;
  logic [1:0]         c4_r, c4_nxt;
  logic [6:0]         c100_r, c100_nxt;
  logic [8:0]         c400_r, c400_nxt;
  logic [DAY_W-1:0]   sd_r, sd_nxt;
  logic [MONTH_W-1:0] sm_r, sm_nxt;
  logic [YEAR_W-1:0]  sy_r, sy_nxt;
  logic [5:0]         sum_r, sum_nxt;
  logic               walk_kick_r;

  logic               in_fire;
  logic               walk_start;
  walk_res_t          walk_res;
  logic [DAY_W-1:0]   in_day;
  logic [MONTH_W-1:0] in_month;
  logic [YEAR_W-1:0]  in_year;
  logic [YEAR_W-1:0]  in_year_ok;
  logic               cur_leap;
  logic [DAY_W-1:0]   cur_len;
  logic [DAY_W-1:0]   set_len;
  logic [DAY_W-1:0]   set_day_ok;
  logic               skip_adj;
  logic [WD_W-1:0]    wd_inc;

  assign in_day   = in_tdata[4:0];
  assign in_month = in_tdata[8:5];
  assign in_year  = in_tdata[22:9];

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign in_year_ok = ((in_year == '0) || (in_year > YMAX)) ? 14'd1 : in_year;

  assign cur_leap = leap_f(year_r, c4_r, c100_r, c400_r);
  assign cur_len  = month_len_f(month_r, cur_leap);
  assign wd_inc   = (wd_r == WD_SUN) ? 3'd1 : wd_r + 3'd1;

  assign set_len  = month_len_f(sm_r, walk_res.leap);
  assign skip_adj = (sy_r > CUTOVER_YEAR) || ((sy_r == CUTOVER_YEAR) && (sm_r >= MONTH_APR));

  assign walk_start = walk_kick_r;

  always_comb begin
    set_day_ok = sd_r;
    if ((sd_r == '0) || (sd_r > set_len)) begin
      set_day_ok = 5'd1;
    end
    if ((sy_r == CUTOVER_YEAR) && (sm_r == MONTH_APR) && (set_day_ok < DAY_SKIP_TO)) begin
      set_day_ok = DAY_SKIP_TO;
    end
  end

  cdw_walk u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (walk_start),
    .target_year (sy_r),
    .res         (walk_res)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    wd_nxt        = wd_r;
    c4_nxt        = c4_r;
    c100_nxt      = c100_r;
    c400_nxt      = c400_r;
    sd_nxt        = sd_r;
    sm_nxt        = sm_r;
    sy_nxt        = sy_r;
    sum_nxt       = sum_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd_t'(in_tuser) == CMD_SET) begin
            sd_nxt    = in_day;
            sm_nxt    = ((in_month == '0) || (in_month > MONTH_DEC)) ? 4'd1 : in_month;
            sy_nxt    = in_year_ok;
            state_nxt = ST_WALK;
          end else begin
            out_valid_nxt = 1'b1;
            wd_nxt        = wd_inc;
            if ((year_r == CUTOVER_YEAR) && (month_r == MONTH_MAR) &&
                (day_r == DAY_LAST_MAR)) begin
              day_nxt   = DAY_SKIP_TO;
              month_nxt = MONTH_APR;
            end else if (day_r >= cur_len) begin
              day_nxt = 5'd1;
              if (month_r == MONTH_DEC) begin
                month_nxt = 4'd1;
                if (year_r >= YMAX) begin
                  year_nxt = 14'd1;
                  c4_nxt   = 2'd1;
                  c100_nxt = 7'd1;
                  c400_nxt = 9'd1;
                  wd_nxt   = WD_SAT;
                end else begin
                  year_nxt = year_r + 14'd1;
                  c4_nxt   = c4_r + 2'd1;
                  c100_nxt = (c100_r == C100_LAST) ? 7'd0 : c100_r + 7'd1;
                  c400_nxt = (c400_r == C400_LAST) ? 9'd0 : c400_r + 9'd1;
                end
              end else begin
                month_nxt = month_r + 4'd1;
              end
            end else begin
              day_nxt = day_r + 5'd1;
            end
          end
        end
      end
      ST_WALK: begin
        if (walk_res.done) begin
          sd_nxt    = set_day_ok;
          sum_nxt   = 6'd5 + {3'd0, walk_res.acc} + {5'd0, skip_adj}
                    + {3'd0, days_before_mod7_f(sm_r)}
                    + {5'd0, (sm_r > MONTH_FEB) && walk_res.leap}
                    + {1'b0, set_day_ok} - 6'd1;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        day_nxt       = sd_r;
        month_nxt     = sm_r;
        year_nxt      = sy_r;
        wd_nxt        = mod7_f(sum_r) + 3'd1;
        c4_nxt        = walk_res.c4;
        c100_nxt      = walk_res.c100;
        c400_nxt      = walk_res.c400;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      walk_kick_r <= 1'b0;
      day_r       <= 5'd1;
      month_r     <= 4'd1;
      year_r      <= 14'd1;
      wd_r        <= WD_SAT;
      c4_r        <= 2'd1;
      c100_r      <= 7'd1;
      c400_r      <= 9'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      walk_kick_r <= (state_r == ST_IDLE) && (state_nxt == ST_WALK);
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      wd_r        <= wd_nxt;
      c4_r        <= c4_nxt;
      c100_r      <= c100_nxt;
      c400_r      <= c400_nxt;
    end
    sd_r  <= sd_nxt;
    sm_r  <= sm_nxt;
    sy_r  <= sy_nxt;
    sum_r <= sum_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, wd_r, year_r, month_r, day_r};

endmodule

// ===== dv/calendar_date_counter_weekday_test.sv =====
// ----------------------------------------------------------------------------
// calendar_date_counter_weekday_test
// Self-checking bench for the calendar date and weekday counter. Drives set and
// next-day transactions, directed edge dates first (cutover, leap rules, year
// wrap, sanitizing), then random set-and-advance runs and noise, with random
// gaps on both sides and one long output stall. A date tracker predicts every
// result and compares it field by field.
// ----------------------------------------------------------------------------
module calendar_date_counter_weekday_test;
  import cdw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 700;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic [WD_W-1:0]    wday;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  class calendar_checker;
    int unsigned cur_d, cur_m, cur_y, cur_wd;
    date_t       pending_dates[$];
    int          errors;
    int unsigned cum_days[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    function new();
      cur_d  = 1;
      cur_m  = 1;
      cur_y  = 1;
      cur_wd = WD_SAT;
      errors = 0;
    endfunction

    function bit leap_rule(int unsigned y);
      if (y <= CUTOVER_YEAR) return (y % 4) == 0;
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function int unsigned month_days(int unsigned m, int unsigned y);
      case (m)
        MONTH_FEB: return leap_rule(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default: return 31;
      endcase
    endfunction

    function int unsigned leap_count(int unsigned y);
      int unsigned c;
      c = CUTOVER_YEAR;
      if (y <= c) return y / 4;
      return c / 4 + (y / 4 - y / 100 + y / 400) - (c / 4 - c / 100 + c / 400);
    endfunction

    function int unsigned weekday_for(int unsigned d, int unsigned m, int unsigned y);
      longint unsigned n;
      n = 365 * longint'(y - 1) + leap_count(y - 1);
      if (y > CUTOVER_YEAR) n -= DAY_SKIP_TO - 1;
      n += cum_days[m - 1];
      if (m > MONTH_FEB && leap_rule(y)) n += 1;
      n += d - 1;
      if (y == CUTOVER_YEAR && m >= MONTH_APR) n -= DAY_SKIP_TO - 1;
      return int'((5 + n) % 7) + 1;
    endfunction

    function void take_command(cmd_t cmd, logic [23:0] data);
      int unsigned d, m, y;
      date_t nxt;
      if (cmd == CMD_SET) begin
        d = data[4:0];
        m = data[8:5];
        y = data[22:9];
        if (y == 0 || y > YEAR_MAX_DEF) y = 1;
        if (m == 0 || m > MONTH_DEC) m = 1;
        if (d == 0 || d > month_days(m, y)) d = 1;
        if (y == CUTOVER_YEAR && m == MONTH_APR && d < DAY_SKIP_TO) d = DAY_SKIP_TO;
        cur_d  = d;
        cur_m  = m;
        cur_y  = y;
        cur_wd = weekday_for(d, m, y);
      end else if (cur_y == CUTOVER_YEAR && cur_m == MONTH_MAR && cur_d == DAY_LAST_MAR) begin
        cur_d  = DAY_SKIP_TO;
        cur_m  = MONTH_APR;
        cur_wd = cur_wd % 7 + 1;
      end else begin
        cur_wd = cur_wd % 7 + 1;
        cur_d++;
        if (cur_d > month_days(cur_m, cur_y)) begin
          cur_d = 1;
          cur_m++;
          if (cur_m > MONTH_DEC) begin
            cur_m = 1;
            cur_y++;
            if (cur_y > YEAR_MAX_DEF) begin
              cur_y  = 1;
              cur_wd = WD_SAT;
            end
          end
        end
      end
      nxt.day   = DAY_W'(cur_d);
      nxt.month = MONTH_W'(cur_m);
      nxt.year  = YEAR_W'(cur_y);
      nxt.wday  = WD_W'(cur_wd);
      pending_dates.push_back(nxt);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_date(logic [31:0] data);
      date_t got, want;
      got = data[25:0];
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result %0d.%0d.%0d weekday %0d", $time,
                 got.day, got.month, got.year, got.wday);
        errors++;
        return;
      end
      want = pending_dates.pop_front();
      compare_field("cur_day", want.day, got.day);
      compare_field("cur_month", want.month, got.month);
      compare_field("cur_year", want.year, got.year);
      compare_field("weekday", want.wday, got.wday);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  calendar_checker chk = new();
  int sent = 0;
  int taken = 0;

  calendar_date_counter_weekday i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_item(cmd_t cmd, logic [4:0] d, logic [3:0] m, logic [13:0] y);
    int gap;
    gap = ((sent / 64) % 4 == 1) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, y, m, d};
    do @(posedge clk); while (!in_tready);
    chk.take_command(cmd, {1'b0, y, m, d});
    sent++;
  endtask

  initial begin
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == HOLD_AT) begin
        gap = HOLD_CYCLES;
      end else begin
        gap = ((taken / 40) % 3 == 0) ? 0 : $urandom_range(0, 19);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      chk.check_date(out_tdata);
      taken++;
    end
  end

  initial begin
    int unsigned r, run, guard;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_item(CMD_NEXT, 5'd31, 4'd15, 14'h3fff);
    send_item(CMD_SET, 5'd0, 4'd0, 14'd0);
    send_item(CMD_SET, 5'd31, 4'd15, 14'd4);
    send_item(CMD_NEXT, 5'd0, 4'd0, 14'd0);
    send_item(CMD_SET, 5'd29, MONTH_FEB, 14'd1700);
    send_item(CMD_NEXT, 5'd0, 4'd0, 14'd0);
    send_item(CMD_SET, 5'd29, MONTH_FEB, 14'd1900);
    send_item(CMD_SET, 5'd29, MONTH_FEB, 14'd2100);
    send_item(CMD_SET, 5'd29, MONTH_FEB, 14'd2000);
    send_item(CMD_NEXT, 5'd0, 4'd0, 14'd0);
    send_item(CMD_SET, 5'd30, MONTH_FEB, 14'd2000);
    send_item(CMD_SET, DAY_LAST_MAR, MONTH_MAR, CUTOVER_YEAR);
    send_item(CMD_NEXT, 5'd0, 4'd0, 14'd0);
    send_item(CMD_NEXT, 5'd0, 4'd0, 14'd0);
    send_item(CMD_SET, 5'd5, MONTH_APR, CUTOVER_YEAR);
    send_item(CMD_SET, 5'd13, MONTH_APR, CUTOVER_YEAR);
    send_item(CMD_SET, 5'd31, MONTH_APR, 14'd5);
    send_item(CMD_SET, 5'd31, MONTH_DEC, 14'd9999);
    send_item(CMD_NEXT, 5'd0, 4'd0, 14'd0);
    send_item(CMD_NEXT, 5'd0, 4'd0, 14'd0);
    send_item(CMD_SET, 5'd31, MONTH_DEC, CUTOVER_YEAR);
    send_item(CMD_NEXT, 5'd0, 4'd0, 14'd0);
    send_item(CMD_SET, 5'd28, MONTH_FEB, CUTOVER_YEAR);
    send_item(CMD_NEXT, 5'd0, 4'd0, 14'd0);
    send_item(CMD_NEXT, 5'd0, 4'd0, 14'd0);

    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 85) begin
        r = $urandom_range(0, 99);
        if (r < 55)      y = 14'($urandom_range(0, 60));
        else if (r < 70) y = CUTOVER_YEAR;
        else if (r < 88) y = 14'($urandom_range(1880, 1960));
        else if (r < 96) y = 14'($urandom_range(1, 9999));
        else             y = 14'd9999;
        r = $urandom_range(0, 99);
        if (r < 10)      m = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
        else if (r < 30) m = MONTH_FEB;
        else if (r < 45) m = MONTH_DEC;
        else if (r < 60) m = MONTH_MAR;
        else             m = 4'($urandom_range(1, 12));
        r = $urandom_range(0, 99);
        if (r < 45)      d = 5'($urandom_range(27, 31));
        else if (r < 52) d = 5'd0;
        else             d = 5'($urandom_range(0, 31));
        send_item(CMD_SET, d, m, y);
        run = $urandom_range(0, 40);
        repeat (run) send_item(CMD_NEXT, 5'($urandom), 4'($urandom), 14'($urandom));
      end else begin
        send_item(cmd_t'($urandom_range(0, 1)), 5'($urandom), 4'($urandom),
                  14'($urandom_range(0, 9999)));
      end
    end
    in_tvalid <= 1'b0;

    guard = 0;
    while (chk.pending_dates.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (chk.errors == 0 && chk.pending_dates.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (chk.pending_dates.size() != 0) begin
        $display("%0t: %0d results never arrived", $time, chk.pending_dates.size());
      end
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("%0t: timeout", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/cdw_pkg.sv
sv/cdw_walk.sv
sv/calendar_date_counter_weekday.sv
dv/calendar_date_counter_weekday_test.sv
